// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants of the delayed event queue.
// Used by deq_seq and delayed_event_queue; depends on nothing.
package deq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int DELAY_BITS_DEF   = 16;

	localparam logic CMD_POST = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_DUE      = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_DROPPED  = 2'd2
	} kind_t;

endpackage

// ===== hw/rtl/delayed_event_queue.sv =====
// Top level of the delayed event queue: slot memory plus its sequencer.
// Depends on deq_pkg, deq_slot_ram and deq_seq.
//
// A transaction is taken when start is high and busy is low. A post's single
// result (accepted or dropped) appears in the next cycle and busy stays low.
// A tick with pending events keeps busy high through the scan and flush states;
// the scan is set by the single read port of the slot memory, which is walked
// one slot per cycle while survivors are compacted and decremented; a tick with
// an empty table returns at once. Each result is shown on the result ports for
// exactly one cycle while result_valid is high and cannot be held off, so the
// receiver must capture it in that cycle. Due events come out in insertion order,
// the last one of a tick marked by last_of_run.
module delayed_event_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = deq_pkg::PAYLOAD_BITS_DEF,
	parameter int DELAY_BITS = deq_pkg::DELAY_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic [PAYLOAD_BITS-1:0] event_payload,
	input  logic [DELAY_BITS-1:0]   event_delay,
	output logic                    result_valid,
	output logic [1:0]              kind,
	output logic [PAYLOAD_BITS-1:0] due_payload,
	output logic                    last_of_run
);
	import deq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int WW = PAYLOAD_BITS + DELAY_BITS;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;
	kind_t         kind_w;

	assign kind = kind_w;

	deq_slot_ram #(
		.DEPTH(DEPTH),
		.WORD_BITS(WW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	deq_seq #(
		.DEPTH(DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.DELAY_BITS(DELAY_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.event_payload(event_payload),
		.event_delay(event_delay),
		.busy(busy),
		.result_valid(result_valid),
		.kind(kind_w),
		.due_payload(due_payload),
		.last_of_run(last_of_run),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

endmodule

// ===== hw/rtl/deq_slot_ram.sv =====
// Slot memory of the delayed event queue: one write port, one registered read port.
// Each word holds an event payload above its countdown; depends on nothing.
module deq_slot_ram #(
	parameter int DEPTH = 16,
	parameter int WORD_BITS = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WORD_BITS-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WORD_BITS-1:0]     rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/deq_seq.sv =====
// Sequencer of the delayed event queue: handles posts, walks the slots on a tick,
// compacts survivors with a shared decrementer and registers each result.
// Depends on deq_pkg and drives the ports of deq_slot_ram.
module deq_seq #(
	parameter int DEPTH = 16,
	parameter int PAYLOAD_BITS = 32,
	parameter int DELAY_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                command,
	input  logic [PAYLOAD_BITS-1:0]             event_payload,
	input  logic [DELAY_BITS-1:0]               event_delay,
	output logic                                busy,
	output logic                                result_valid,
	output deq_pkg::kind_t                      kind,
	output logic [PAYLOAD_BITS-1:0]             due_payload,
	output logic                                last_of_run,
	output logic                                ram_we,
	output logic [$clog2(DEPTH)-1:0]            ram_waddr,
	output logic [PAYLOAD_BITS+DELAY_BITS-1:0]  ram_wdata,
	output logic [$clog2(DEPTH)-1:0]            ram_raddr,
	input  logic [PAYLOAD_BITS+DELAY_BITS-1:0]  ram_rdata
);
	import deq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = PAYLOAD_BITS + DELAY_BITS;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           pos_q;
	logic [CW-1:0]           keep_q;
	logic                    hold_valid_q;
	logic [PAYLOAD_BITS-1:0] hold_payload_q;

	logic                    accept;
	logic                    full;
	logic [CW-1:0]           pos_inc;
	logic                    scan_last;
	logic [DELAY_BITS-1:0]   rd_cd;
	logic [PAYLOAD_BITS-1:0] rd_pl;
	logic                    rd_due;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign full      = (count_q == CW'(DEPTH));
	assign pos_inc   = pos_q + CW'(1);
	assign scan_last = (pos_inc == count_q);
	assign rd_cd     = ram_rdata[DELAY_BITS-1:0];
	assign rd_pl     = ram_rdata[WW-1:DELAY_BITS];
	assign rd_due    = (rd_cd == '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IW-1:0];
		ram_wdata = {event_payload, event_delay};
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && (command == CMD_POST) && !full;
			end
			ST_SCAN: begin
				ram_raddr = pos_inc[IW-1:0];
				ram_we    = !rd_due;
				ram_waddr = keep_q[IW-1:0];
				ram_wdata = {rd_pl, rd_cd - DELAY_BITS'(1)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pos_q        <= '0;
			keep_q       <= '0;
			hold_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_POST) begin
							result_valid <= 1'b1;
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end else if (count_q != '0) begin
							pos_q   <= '0;
							keep_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_due) begin
						hold_valid_q <= 1'b1;
						if (hold_valid_q) begin
							result_valid <= 1'b1;
						end
					end else begin
						keep_q <= keep_q + CW'(1);
					end
					pos_q <= pos_inc;
					if (scan_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					count_q      <= keep_q;
					hold_valid_q <= 1'b0;
					result_valid <= hold_valid_q;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind        <= full ? KIND_DROPPED : KIND_ACCEPTED;
				due_payload <= '0;
				last_of_run <= 1'b1;
			end
			ST_SCAN: begin
				if (rd_due) begin
					hold_payload_q <= rd_pl;
					kind           <= KIND_DUE;
					due_payload    <= hold_payload_q;
					last_of_run    <= 1'b0;
				end
			end
			ST_FLUSH: begin
				kind        <= KIND_DUE;
				due_payload <= hold_payload_q;
				last_of_run <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
